// ----- rtl/core/scd_pkg.sv -----
// shared types and constants for the spike coincidence detector
package scd_pkg;

  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam int WORD_W     = 32;
  localparam int NOW_W      = 32;
  localparam int NEURON_W   = 11;
  localparam int KEY_W      = 32;

  localparam int WEIGHT_LSB = 0;
  localparam int WEIGHT_W   = 13;
  localparam int TYPE_LSB   = 13;
  localparam int TYPE_W     = 3;
  localparam int TGT_LSB    = 16;

  localparam int CHIP_W     = 16;
  localparam int CORE_W     = 5;
  localparam int POP_W      = 16;
  localparam int CHIP_LSB   = 16;
  localparam int CORE_LSB   = 11;

  localparam logic [CHIP_W-1:0] CHIP_RST = 16'h0000;
  localparam logic [CORE_W-1:0] CORE_RST = 5'd1;
  localparam logic [POP_W-1:0]  POP_RST  = 16'h0000;

  // field slots in one state memory entry
  localparam int F_FIRST    = 0;
  localparam int F_SECOND   = 1;
  localparam int F_FIRE     = 2;
  localparam int F_REFR     = 3;
  localparam int F_WIN      = 4;
  localparam int NUM_FIELDS = 5;

  typedef enum logic {
    OP_EVENT = 1'b0,
    OP_LOAD  = 1'b1
  } scd_op_e;

  typedef enum logic [TYPE_W-1:0] {
    TYPE_FIRST  = 3'd0,
    TYPE_SECOND = 3'd1
  } scd_type_e;

  typedef enum logic [1:0] {
    REG_CHIP_ID  = 2'd0,
    REG_CORE_ID  = 2'd1,
    REG_POP_BASE = 2'd2
  } scd_reg_e;

  typedef struct packed {
    logic                op;
    logic [WORD_W-1:0]   syn_word;
    logic [NOW_W-1:0]    now_us;
    logic                end_of_row;
    logic [NEURON_W-1:0] param_neuron;
    logic [NOW_W-1:0]    param_refractory;
    logic [NOW_W-1:0]    param_window;
  } scd_item_t;

  typedef struct packed {
    logic write;
    logic fire;
  } scd_upd_t;

  typedef struct packed {
    logic [CHIP_W-1:0] chip_id;
    logic [CORE_W-1:0] core_id;
    logic [POP_W-1:0]  population_base;
  } scd_cfg_t;

  function automatic logic [NEURON_W-1:0] neuron_of(input scd_item_t item);
    if (item.op == OP_LOAD) begin
      return item.param_neuron;
    end
    return item.syn_word[TGT_LSB +: NEURON_W];
  endfunction

endpackage

// ----- rtl/core/scd_if.sv -----
// valid/ready channel interfaces for synaptic items and spike keys
interface scd_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] syn_word;
  logic [31:0] now_us;
  logic        end_of_row;
  logic [10:0] param_neuron;
  logic [31:0] param_refractory;
  logic [31:0] param_window;

  modport source (
    output valid, op, syn_word, now_us, end_of_row, param_neuron, param_refractory,
           param_window,
    input  ready
  );
  modport sink (
    input  valid, op, syn_word, now_us, end_of_row, param_neuron, param_refractory,
           param_window,
    output ready
  );
endinterface

interface scd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] spike_key;

  modport source (output valid, spike_key, input ready);
  modport sink (input valid, spike_key, output ready);
endinterface

// ----- rtl/core/spike_coincidence_detector_unit.sv -----
// spike coincidence detector top level: state memory pipeline and output register
//
//   port      dir   beat
//   in_i      in    one synaptic event or parameter load
//   out_o     out   one spike key
//   apb       in    chip, core and population id registers
//
// one item per cycle sustained while no key is stalled; a key appears once
// its item has passed the update stage and the output register. the neuron
// state memory is read on accept and written back as the item leaves the
// update stage, with the last write forwarded to the next item.
// after reset a sweep zeroes all NEURONS entries of the state memory; in_i.ready
// stays low meanwhile, apb writes are taken as usual. a stalled key holds the update stage, which then holds in_i.
module spike_coincidence_detector_unit #(
  parameter int NEURONS   = 2048,
  parameter int TIME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  scd_in_if.sink                      in_i,
  scd_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scd_pkg::PADDR_W-1:0] paddr,
  input  logic [scd_pkg::PDATA_W-1:0] pwdata,
  output logic [scd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import scd_pkg::*;

  localparam int NW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int EW = NUM_FIELDS * TIME_BITS;

  scd_cfg_t  cfg;
  scd_item_t in_item, s1_item_q;
  scd_upd_t  upd;

  logic          clr_q, clr_d;
  logic [NW-1:0] clr_addr_q, clr_addr_d;
  logic          s1_valid_q, s1_valid_d;
  logic          out_valid_q, out_valid_d;
  logic [KEY_W-1:0] out_key_q, key;
  logic          fwd_valid_q, fwd_valid_d;
  logic [NW-1:0] fwd_addr_q;
  logic [EW-1:0] fwd_data_q;
  logic [EW-1:0] rd_data, entry_cur, entry_new, mem_wdata;
  logic [NEURON_W-1:0] rd_nrn, s1_nrn;
  logic [NW-1:0] rd_addr, s1_addr, mem_waddr;
  logic          in_ready, in_fire, s1_go, upd_wr, mem_we;

  scd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_item = '{
    op:               in_i.op,
    syn_word:         in_i.syn_word,
    now_us:           in_i.now_us,
    end_of_row:       in_i.end_of_row,
    param_neuron:     in_i.param_neuron,
    param_refractory: in_i.param_refractory,
    param_window:     in_i.param_window
  };

  assign s1_go    = !out_valid_q || out_o.ready;
  assign in_ready = !clr_q && (!s1_valid_q || s1_go);
  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign rd_nrn  = neuron_of(in_item);
  assign s1_nrn  = neuron_of(s1_item_q);
  assign rd_addr = rd_nrn[NW-1:0];
  assign s1_addr = s1_nrn[NW-1:0];

  assign upd_wr    = s1_valid_q && s1_go && upd.write;
  assign mem_we    = clr_q || upd_wr;
  assign mem_waddr = clr_q ? clr_addr_q : s1_addr;
  assign mem_wdata = clr_q ? '0 : entry_new;

  scd_state_mem #(
    .DEPTH (NEURONS),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // last write bypasses the read captured on the same edge
  assign entry_cur = (fwd_valid_q && fwd_addr_q == s1_addr) ? fwd_data_q : rd_data;

  scd_update #(
    .TIME_BITS (TIME_BITS),
    .NEURONS   (NEURONS)
  ) u_upd (
    .item_i  (s1_item_q),
    .entry_i (entry_cur),
    .cfg_i   (cfg),
    .entry_o (entry_new),
    .upd_o   (upd),
    .key_o   (key)
  );

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == NW'(NEURONS - 1)) begin
        clr_d = 1'b0;
      end
    end
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && s1_go) begin
      out_valid_d = upd.fire;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    fwd_valid_d = fwd_valid_q || upd_wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item;
    end
    if (upd_wr) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= entry_new;
    end
    if (s1_valid_q && s1_go && upd.fire) begin
      out_key_q <= key;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.spike_key = out_key_q;

  // a key only appears after the update stage advanced
  a_key_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_go))
    else $error("key without update stage advance");

  // nothing moves through the pipeline while the memory sweep runs
  a_idle_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_valid_q && !out_valid_q && !upd_wr)
    else $error("pipeline active during memory sweep");

  // a stalled update stage keeps its item and does not write
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_addr) && !$past(upd_wr))
    else $error("update stage changed while stalled");

endmodule

// ----- rtl/core/scd_state_mem.sv -----
// per-neuron state memory, one write port and one registered read port
module scd_state_mem #(
  parameter int  DEPTH = 2048,
  parameter int  WIDTH = 160,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/scd_cfg_regs.sv -----
// apb configuration registers for chip, core and population ids
module scd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scd_pkg::PADDR_W-1:0] paddr,
  input  logic [scd_pkg::PDATA_W-1:0] pwdata,
  output logic [scd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output scd_pkg::scd_cfg_t           cfg_o
);
  import scd_pkg::*;

  logic [CHIP_W-1:0] chip_q, chip_d;
  logic [CORE_W-1:0] core_q, core_d;
  logic [POP_W-1:0]  pop_q, pop_d;
  logic              wr_en;
  logic [1:0]        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[3:2];

  always_comb begin
    chip_d = chip_q;
    core_d = core_q;
    pop_d  = pop_q;
    if (wr_en) begin
      unique case (idx)
        REG_CHIP_ID:  chip_d = pwdata[CHIP_W-1:0];
        REG_CORE_ID:  core_d = pwdata[CORE_W-1:0];
        REG_POP_BASE: pop_d  = pwdata[POP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHIP_ID:  prdata = {{(PDATA_W-CHIP_W){1'b0}}, chip_q};
      REG_CORE_ID:  prdata = {{(PDATA_W-CORE_W){1'b0}}, core_q};
      REG_POP_BASE: prdata = {{(PDATA_W-POP_W){1'b0}}, pop_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_q <= CHIP_RST;
      core_q <= CORE_RST;
      pop_q  <= POP_RST;
    end else begin
      chip_q <= chip_d;
      core_q <= core_d;
      pop_q  <= pop_d;
    end
  end

  assign cfg_o = '{chip_id: chip_q, core_id: core_q, population_base: pop_q};

endmodule

// ----- rtl/core/scd_update.sv -----
// neuron update: parameter load, refractory check, coincidence test and key build
module scd_update #(
  parameter int TIME_BITS = 32,
  parameter int NEURONS   = 2048
) (
  input  scd_pkg::scd_item_t                            item_i,
  input  logic [scd_pkg::NUM_FIELDS*TIME_BITS-1:0]      entry_i,
  input  scd_pkg::scd_cfg_t                             cfg_i,
  output logic [scd_pkg::NUM_FIELDS*TIME_BITS-1:0]      entry_o,
  output scd_pkg::scd_upd_t                             upd_o,
  output logic [scd_pkg::KEY_W-1:0]                     key_o
);
  import scd_pkg::*;

  logic [TIME_BITS-1:0] now, first_t, second_t, fire_t, refr, win, other;
  logic [TIME_BITS-1:0] since_fire, since_other;
  logic [NEURON_W-1:0]  tgt;
  logic [TYPE_W-1:0]    syn_type;
  logic                 in_range, ev_ok, active, coincide;

  assign now      = item_i.now_us[TIME_BITS-1:0];
  assign first_t  = entry_i[F_FIRST*TIME_BITS +: TIME_BITS];
  assign second_t = entry_i[F_SECOND*TIME_BITS +: TIME_BITS];
  assign fire_t   = entry_i[F_FIRE*TIME_BITS +: TIME_BITS];
  assign refr     = entry_i[F_REFR*TIME_BITS +: TIME_BITS];
  assign win      = entry_i[F_WIN*TIME_BITS +: TIME_BITS];

  assign tgt      = neuron_of(item_i);
  assign in_range = ({21'b0, tgt} < 32'(NEURONS));
  assign syn_type = item_i.syn_word[TYPE_LSB +: TYPE_W];
  assign ev_ok    = (item_i.syn_word[WEIGHT_LSB +: WEIGHT_W] != '0) &&
                    (syn_type == TYPE_FIRST || syn_type == TYPE_SECOND) && in_range;

  assign since_fire  = now - fire_t;
  assign other       = (syn_type == TYPE_FIRST) ? second_t : first_t;
  assign since_other = now - other;
  assign active      = ev_ok && (since_fire >= refr);
  assign coincide    = active && (since_other <= win);

  always_comb begin
    entry_o    = entry_i;
    upd_o      = '{write: 1'b0, fire: 1'b0};
    if (item_i.op == OP_LOAD) begin
      entry_o[F_REFR*TIME_BITS +: TIME_BITS] = item_i.param_refractory[TIME_BITS-1:0];
      entry_o[F_WIN*TIME_BITS +: TIME_BITS]  = item_i.param_window[TIME_BITS-1:0];
      upd_o.write = in_range;
    end else begin
      if (syn_type == TYPE_FIRST) begin
        entry_o[F_FIRST*TIME_BITS +: TIME_BITS] = now;
      end else begin
        entry_o[F_SECOND*TIME_BITS +: TIME_BITS] = now;
      end
      if (coincide) begin
        entry_o[F_FIRE*TIME_BITS +: TIME_BITS] = now;
      end
      upd_o.write = active;
      upd_o.fire  = coincide;
    end
  end

  assign key_o = {cfg_i.chip_id, {CHIP_LSB{1'b0}}} |
                 {{(KEY_W-CORE_LSB-CORE_W){1'b0}}, cfg_i.core_id, {CORE_LSB{1'b0}}} |
                 {{(KEY_W-POP_W){1'b0}}, cfg_i.population_base} |
                 {{(KEY_W-NEURON_W){1'b0}}, tgt};

endmodule

// ----- test/scd_checker.sv -----
// checker for the spike coincidence detector: neuron bank model and spike key compare
module scd_checker
  import scd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  scd_in_if                  in_mon,
  scd_out_if                 out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 errors_o,
  output int                 pending_o
);

  localparam int NEURONS = 1 << NEURON_W;

  logic [NOW_W-1:0] first_t  [NEURONS];
  logic [NOW_W-1:0] second_t [NEURONS];
  logic [NOW_W-1:0] fire_t   [NEURONS];
  logic [NOW_W-1:0] refr_t   [NEURONS];
  logic [NOW_W-1:0] win_t    [NEURONS];

  scd_cfg_t         cfg;
  logic [KEY_W-1:0] expected_keys [$];
  int               errors;

  task automatic model_item(input scd_item_t it);
    logic [WEIGHT_W-1:0] wt;
    logic [TYPE_W-1:0]   typ;
    logic [NEURON_W-1:0] tgt;
    logic [NOW_W-1:0]    since_fire;
    logic [NOW_W-1:0]    since_other;
    if (it.op == OP_LOAD) begin
      refr_t[it.param_neuron] = it.param_refractory;
      win_t[it.param_neuron]  = it.param_window;
      return;
    end
    wt  = it.syn_word[WEIGHT_LSB +: WEIGHT_W];
    typ = it.syn_word[TYPE_LSB +: TYPE_W];
    tgt = it.syn_word[TGT_LSB +: NEURON_W];
    if (wt == '0 || (typ != TYPE_FIRST && typ != TYPE_SECOND)) begin
      return;
    end
    since_fire = it.now_us - fire_t[tgt];
    if (since_fire < refr_t[tgt]) begin
      return;
    end
    if (typ == TYPE_FIRST) begin
      since_other  = it.now_us - second_t[tgt];
      first_t[tgt] = it.now_us;
    end else begin
      since_other   = it.now_us - first_t[tgt];
      second_t[tgt] = it.now_us;
    end
    if (since_other <= win_t[tgt]) begin
      fire_t[tgt] = it.now_us;
      expected_keys.push_back({cfg.chip_id, 16'h0000}
                              | (KEY_W'(cfg.core_id) << CORE_LSB)
                              | KEY_W'(cfg.population_base)
                              | KEY_W'(tgt));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    scd_item_t        it;
    logic [KEY_W-1:0] want;
    if (!rst_ni) begin
      for (int n = 0; n < NEURONS; n++) begin
        first_t[n]  = '0;
        second_t[n] = '0;
        fire_t[n]   = '0;
        refr_t[n]   = '0;
        win_t[n]    = '0;
      end
      cfg.chip_id         = CHIP_RST;
      cfg.core_id         = CORE_RST;
      cfg.population_base = POP_RST;
      expected_keys.delete();
      errors    = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (scd_reg_e'(paddr[3:2]))
          REG_CHIP_ID:  cfg.chip_id         = pwdata[CHIP_W-1:0];
          REG_CORE_ID:  cfg.core_id         = pwdata[CORE_W-1:0];
          REG_POP_BASE: cfg.population_base = pwdata[POP_W-1:0];
          default: ;
        endcase
      end
      // keys leaving now belong to earlier beats
      if (out_mon.valid && out_mon.ready) begin
        if (expected_keys.size() == 0) begin
          $error("spike_key beat with nothing expected: actual %h", out_mon.spike_key);
          errors++;
        end else begin
          want = expected_keys.pop_front();
          if (out_mon.spike_key !== want) begin
            $error("spike_key mismatch: expected %h, actual %h", want, out_mon.spike_key);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it.op               = in_mon.op;
        it.syn_word         = in_mon.syn_word;
        it.now_us           = in_mon.now_us;
        it.end_of_row       = in_mon.end_of_row;
        it.param_neuron     = in_mon.param_neuron;
        it.param_refractory = in_mon.param_refractory;
        it.param_window     = in_mon.param_window;
        model_item(it);
      end
      errors_o  <= errors;
      pending_o <= expected_keys.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top for the spike coincidence detector: stimulus, apb setup and verdict
module tb_top;
  import scd_pkg::*;

  localparam int LIMIT = 300000;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_CHOKE
  } rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int                 err_cnt;
  int                 keys_pending;
  int                 cycle_cnt;
  int                 burst_left;
  int                 rx_cnt;
  rx_mode_e           rx_mode;
  logic [NOW_W-1:0]   t_now;
  logic [NEURON_W-1:0] hot [8];

  scd_in_if  in_if ();
  scd_out_if out_if ();

  spike_coincidence_detector_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scd_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (err_cnt),
    .pending_o (keys_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // key sink stalls follow a randomly redrawn mode: open, random, periodic or choke
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_cnt       <= 0;
      rx_mode      <= RX_OPEN;
    end else begin
      rx_cnt <= rx_cnt + 1;
      if (rx_cnt % 97 == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
      end
      case (rx_mode)
        RX_OPEN:     out_if.ready <= 1'b1;
        RX_RANDOM:   out_if.ready <= ($urandom_range(0, 2) != 0);
        RX_PERIODIC: out_if.ready <= (rx_cnt % 5 < 2);
        default:     out_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  function automatic scd_item_t mk_event(input logic [TYPE_W-1:0] typ,
                                         input logic [WEIGHT_W-1:0] wt,
                                         input logic [NEURON_W-1:0] tgt,
                                         input logic [NOW_W-1:0] now);
    scd_item_t it;
    it.op               = OP_EVENT;
    it.syn_word         = {5'($urandom), tgt, typ, wt};
    it.now_us           = now;
    it.end_of_row       = 1'($urandom);
    it.param_neuron     = 11'($urandom);
    it.param_refractory = $urandom;
    it.param_window     = $urandom;
    return it;
  endfunction

  function automatic scd_item_t mk_load(input logic [NEURON_W-1:0] nrn,
                                        input logic [NOW_W-1:0] refr,
                                        input logic [NOW_W-1:0] win);
    scd_item_t it;
    it.op               = OP_LOAD;
    it.syn_word         = $urandom;
    it.now_us           = $urandom;
    it.end_of_row       = 1'($urandom);
    it.param_neuron     = nrn;
    it.param_refractory = refr;
    it.param_window     = win;
    return it;
  endfunction

  task automatic push_item(input scd_item_t it);
    in_if.valid            <= 1'b1;
    in_if.op               <= it.op;
    in_if.syn_word         <= it.syn_word;
    in_if.now_us           <= it.now_us;
    in_if.end_of_row       <= it.end_of_row;
    in_if.param_neuron     <= it.param_neuron;
    in_if.param_refractory <= it.param_refractory;
    in_if.param_window     <= it.param_window;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (keys_pending != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input scd_reg_e r, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CHIP_W-1:0] chip, input logic [CORE_W-1:0] core,
                           input logic [POP_W-1:0] pop);
    reg_write(REG_CHIP_ID, PDATA_W'(chip));
    reg_write(REG_CORE_ID, PDATA_W'(core));
    reg_write(REG_POP_BASE, PDATA_W'(pop));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int n);
    scd_item_t          it;
    logic [NOW_W-1:0]   refr;
    logic [NOW_W-1:0]   win;
    logic [WEIGHT_W-1:0] wt;
    logic [NEURON_W-1:0] nrn;
    int                 sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        t_now = $urandom;
      end else if (sel < 3) begin
        t_now = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      end
      t_now = t_now + $urandom_range(0, 12);
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        nrn = ($urandom_range(0, 4) == 0) ? 11'($urandom) : hot[$urandom_range(0, 7)];
        case ($urandom_range(0, 9))
          0:       refr = '0;
          1:       refr = $urandom;
          2:       refr = '1;
          default: refr = $urandom_range(0, 20);
        endcase
        case ($urandom_range(0, 9))
          0:       win = '0;
          1, 2:    win = $urandom;
          3:       win = '1;
          default: win = $urandom_range(0, 40);
        endcase
        it = mk_load(nrn, refr, win);
      end else if (sel < 87) begin
        wt = ($urandom_range(0, 29) == 0) ? '0 : WEIGHT_W'($urandom_range(1, 8191));
        it = mk_event($urandom_range(0, 1) ? TYPE_SECOND : TYPE_FIRST, wt,
                      hot[$urandom_range(0, 7)], t_now);
      end else begin
        it = mk_event(TYPE_FIRST, 1, 0, ($urandom_range(0, 1) != 0) ? t_now : $urandom);
        it.syn_word = $urandom;
      end
      push_item(it);
      if (i == n / 2) begin
        drain();
      end
    end
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    in_if.valid            <= 1'b0;
    in_if.op               <= OP_EVENT;
    in_if.syn_word         <= '0;
    in_if.now_us           <= '0;
    in_if.end_of_row       <= 1'b0;
    in_if.param_neuron     <= '0;
    in_if.param_refractory <= '0;
    in_if.param_window     <= '0;
    cycle_cnt              <= 0;
    burst_left = $urandom_range(1, 20);
    hot[0] = '0;
    hot[1] = '1;
    for (int k = 2; k < 8; k++) begin
      hot[k] = 11'($urandom);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_cfg(16'hFFFF, 5'd0, 16'h0000);

    push_item(mk_load(0, 5, 10));
    push_item(mk_load(11'h7FF, 0, 32'hFFFF_FFFF));
    // zero weight and unknown types
    push_item(mk_event(TYPE_FIRST, 0, 0, 50));
    push_item(mk_event(3'd3, 5, 0, 50));
    push_item(mk_event(3'd7, 13'h1FFF, 11'h7FF, 50));
    // out of window, then coincidences and a refractory drop
    push_item(mk_event(TYPE_FIRST, 1, 0, 100));
    push_item(mk_event(TYPE_SECOND, 13'h1FFF, 0, 105));
    push_item(mk_event(TYPE_FIRST, 7, 0, 107));
    push_item(mk_event(TYPE_FIRST, 9, 0, 115));
    push_item(mk_event(TYPE_SECOND, 2, 0, 121));
    push_item(mk_event(TYPE_SECOND, 2, 0, 140));
    // widest window and time wrap
    push_item(mk_event(TYPE_FIRST, 13'h1FFF, 11'h7FF, 32'hFFFF_FFFF));
    push_item(mk_event(TYPE_SECOND, 1, 11'h7FF, 3));
    // longest refractory, then zero window
    push_item(mk_load(0, 32'hFFFF_FFFF, 0));
    push_item(mk_event(TYPE_FIRST, 3, 0, 200));
    push_item(mk_load(0, 0, 0));
    push_item(mk_event(TYPE_FIRST, 3, 0, 300));
    push_item(mk_event(TYPE_SECOND, 3, 0, 300));
    // untouched neuron fires on equal times
    push_item(mk_event(TYPE_SECOND, 1, 5, 0));
    drain();

    t_now = 1000;
    write_cfg(16'h0000, 5'd31, 16'h0000);
    run_phase(220);
    drain();
    write_cfg(16'($urandom), 5'($urandom), 16'($urandom) & 16'h00F0);
    run_phase(210);
    drain();
    write_cfg(16'hFFFF, 5'd31, 16'hFFFF);
    run_phase(210);
    drain();
    write_cfg(CHIP_RST, CORE_RST, POP_RST);
    run_phase(210);
    drain();

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/scd_pkg.sv
rtl/core/scd_if.sv
rtl/core/scd_state_mem.sv
rtl/core/scd_cfg_regs.sv
rtl/core/scd_update.sv
rtl/core/spike_coincidence_detector_unit.sv
test/scd_checker.sv
test/tb_top.sv
